// ----- hdl/vwd_pkg.sv -----
// Shared types and constants for the vertex weld block.
// Used by every module under hdl; depends on nothing.
package vwd_pkg;

  localparam int MAX_VERTS  = 4096;
  localparam int HASH_SLOTS = 8192;
  localparam int VIDX_W     = 12;   // vertex number width
  localparam int VCNT_W     = 13;   // vertex count width, holds MAX_VERTS
  localparam int SLOT_W     = 13;   // hash slot address width
  localparam int EPOCH_W    = 8;    // table generation tag

  localparam logic [31:0]        NEG_ZERO  = 32'h8000_0000;
  localparam logic [SLOT_W-1:0]  HASH_K    = SLOT_W'(32'h9e37_79b1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_START = EPOCH_W'(1);

  typedef struct packed {
    logic [31:0] corner0_x;
    logic [31:0] corner0_y;
    logic [31:0] corner0_z;
    logic [31:0] corner1_x;
    logic [31:0] corner1_y;
    logic [31:0] corner1_z;
    logic [31:0] corner2_x;
    logic [31:0] corner2_y;
    logic [31:0] corner2_z;
    logic        first_of_mesh;
    logic        last_of_mesh;
  } tri_in_t;

  typedef struct packed {
    logic [VIDX_W-1:0] index0;
    logic [VIDX_W-1:0] index1;
    logic [VIDX_W-1:0] index2;
    logic [2:0]        new_mask;
    logic              kept;
    logic [VCNT_W-1:0] vertex_total;
    logic              table_full;
    logic              mesh_empty;
    logic              last_out;
  } tri_out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } corner_key_t;

  // One classified triangle handed from front to back
  typedef struct packed {
    corner_key_t [2:0]       key;
    logic [2:0][SLOT_W-1:0]  hash;
    logic                    first;
    logic                    last;
  } work_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [VIDX_W-1:0]  vertex;
  } slot_t;

  // Fold negative zero onto positive zero
  function automatic logic [31:0] norm_word(input logic [31:0] w);
    norm_word = (w == NEG_ZERO) ? 32'h0 : w;
  endfunction

endpackage

// ----- hdl/vwd_front.sv -----
// Front part: accepts triangles, normalises keys and hashes all three corners.
// Depends on vwd_pkg.
module vwd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            tri_valid,
  output logic            tri_stall,
  input  vwd_pkg::tri_in_t tri_data,
  output logic            push,
  output vwd_pkg::work_t  push_data,
  input  logic            q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MIX  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                            state, state_next;
  vwd_pkg::work_t                     work;
  logic [2:0][vwd_pkg::SLOT_W-1:0]    part;
  logic [2:0][2*vwd_pkg::SLOT_W-1:0]  prod_a;
  logic [2:0][2*vwd_pkg::SLOT_W-1:0]  prod_b;
  logic                               accept;

  assign tri_stall = (state != F_IDLE);
  assign accept    = tri_valid && !tri_stall;

  // Multiply stages of the hash, only low slot bits matter
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_a[c] = {{vwd_pkg::SLOT_W{1'b0}}, work.key[c].x[vwd_pkg::SLOT_W-1:0]} *
                  {{vwd_pkg::SLOT_W{1'b0}}, vwd_pkg::HASH_K};
      prod_b[c] = {{vwd_pkg::SLOT_W{1'b0}}, part[c]} *
                  {{vwd_pkg::SLOT_W{1'b0}}, vwd_pkg::HASH_K};
    end
  end

  always_comb begin
    push_data = work;
    for (int c = 0; c < 3; c++) begin
      push_data.hash[c] = prod_b[c][vwd_pkg::SLOT_W-1:0] +
                          work.key[c].z[vwd_pkg::SLOT_W-1:0];
    end
  end

  assign push = (state == F_PUSH) && !q_full;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept) state_next = F_MIX;
      F_MIX:  state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture normalised keys, then the first mix step
  always_ff @(posedge clk) begin
    if (accept) begin
      work.key[0] <= '{vwd_pkg::norm_word(tri_data.corner0_x),
                       vwd_pkg::norm_word(tri_data.corner0_y),
                       vwd_pkg::norm_word(tri_data.corner0_z)};
      work.key[1] <= '{vwd_pkg::norm_word(tri_data.corner1_x),
                       vwd_pkg::norm_word(tri_data.corner1_y),
                       vwd_pkg::norm_word(tri_data.corner1_z)};
      work.key[2] <= '{vwd_pkg::norm_word(tri_data.corner2_x),
                       vwd_pkg::norm_word(tri_data.corner2_y),
                       vwd_pkg::norm_word(tri_data.corner2_z)};
      work.hash   <= '0;
      work.first  <= tri_data.first_of_mesh;
      work.last   <= tri_data.last_of_mesh;
    end
    if (state == F_MIX) begin
      for (int c = 0; c < 3; c++) begin
        part[c] <= prod_a[c][vwd_pkg::SLOT_W-1:0] + work.key[c].y[vwd_pkg::SLOT_W-1:0];
      end
    end
  end

endmodule

// ----- hdl/vwd_queue.sv -----
// Two-entry queue between the front and back parts.
// Depends on vwd_pkg.
module vwd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vwd_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vwd_pkg::work_t head
);

  vwd_pkg::work_t entry [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/vwd_back.sv -----
// Back part: probes the hash table for each corner, inserts new vertices,
// and holds the result register. Depends on vwd_pkg.
module vwd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  vwd_pkg::work_t   head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output vwd_pkg::tri_out_t res_data
);

  typedef enum logic [5:0] {
    B_SWEEP = 6'b000001,
    B_IDLE  = 6'b000010,
    B_PROBE = 6'b000100,
    B_SLOT  = 6'b001000,
    B_KEY   = 6'b010000,
    B_DONE  = 6'b100000
  } bstate_t;

  bstate_t                          state;
  vwd_pkg::work_t                   cur;
  logic [vwd_pkg::SLOT_W-1:0]       sweep_addr;
  logic                             resume;
  logic [vwd_pkg::EPOCH_W-1:0]      epoch;
  logic [vwd_pkg::VCNT_W-1:0]       vcount;
  logic                             kept_any;
  logic [1:0]                       corner;
  logic [1:0]                       corner_nx;
  logic [vwd_pkg::SLOT_W-1:0]       pos;
  logic [2:0][vwd_pkg::VIDX_W-1:0]  idx;
  logic [2:0]                       mask;
  logic                             full;

  vwd_pkg::slot_t                   slot_mem [vwd_pkg::HASH_SLOTS];
  vwd_pkg::corner_key_t             key_mem  [vwd_pkg::MAX_VERTS];
  vwd_pkg::slot_t                   slot_rd;
  vwd_pkg::corner_key_t             key_rd;

  logic                             slot_we;
  logic [vwd_pkg::SLOT_W-1:0]       slot_wa;
  vwd_pkg::slot_t                   slot_wd;
  logic                             key_we;
  logic                             slot_live;
  logic                             store_full;
  logic                             key_hit;
  logic                             kept;
  logic                             out_free;

  assign corner_nx  = corner + 2'd1;
  assign slot_live  = (slot_rd.epoch == epoch);
  assign store_full = (vcount == vwd_pkg::VCNT_W'(vwd_pkg::MAX_VERTS));
  assign key_hit    = (key_rd == cur.key[corner]);
  assign kept       = !full && (idx[0] != idx[1]) && (idx[1] != idx[2]) &&
                      (idx[0] != idx[2]);
  assign out_free   = !res_valid || !res_stall;
  assign pop        = (state == B_IDLE) && !q_empty;

  // Slot writes come from the sweep or an insert
  always_comb begin
    slot_we = 1'b0;
    slot_wa = pos;
    slot_wd = '{epoch: epoch, vertex: vcount[vwd_pkg::VIDX_W-1:0]};
    key_we  = 1'b0;
    if (state == B_SWEEP) begin
      slot_we = 1'b1;
      slot_wa = sweep_addr;
      slot_wd = '{epoch: vwd_pkg::EPOCH_SWEPT, vertex: '0};
    end else if (state == B_SLOT && !slot_live && !store_full) begin
      slot_we = 1'b1;
      key_we  = 1'b1;
    end
  end

  // Table memories with registered reads
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[vcount[vwd_pkg::VIDX_W-1:0]] <= cur.key[corner];
    key_rd <= key_mem[slot_rd.vertex];
  end

  // Sequencer: sweep, take a triangle, probe each corner, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_SWEEP;
      sweep_addr <= '0;
      resume     <= 1'b0;
      epoch      <= vwd_pkg::EPOCH_START;
      vcount     <= '0;
      kept_any   <= 1'b0;
      corner     <= '0;
    end else begin
      unique case (state)
        B_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == vwd_pkg::SLOT_W'(vwd_pkg::HASH_SLOTS - 1)) begin
            epoch <= vwd_pkg::EPOCH_START;
            state <= resume ? B_PROBE : B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            cur    <= head;
            corner <= '0;
            pos    <= head.hash[0];
            mask   <= '0;
            full   <= 1'b0;
            if (head.first && epoch == vwd_pkg::EPOCH_MAX) begin
              sweep_addr <= '0;
              resume     <= 1'b1;
              state      <= B_SWEEP;
            end else begin
              state <= B_PROBE;
            end
            if (head.first) begin
              vcount   <= '0;
              kept_any <= 1'b0;
              if (epoch != vwd_pkg::EPOCH_MAX) epoch <= epoch + 1'b1;
            end
          end
        end
        B_PROBE: state <= B_SLOT;
        B_SLOT: begin
          if (slot_live) begin
            state <= B_KEY;
          end else begin
            if (store_full) begin
              idx[corner] <= '0;
              full        <= 1'b1;
            end else begin
              idx[corner]  <= vcount[vwd_pkg::VIDX_W-1:0];
              mask[corner] <= 1'b1;
              vcount       <= vcount + 1'b1;
            end
            if (corner == 2'd2) begin
              state <= B_DONE;
            end else begin
              corner <= corner_nx;
              pos    <= cur.hash[corner_nx];
              state  <= B_PROBE;
            end
          end
        end
        B_KEY: begin
          if (key_hit) begin
            idx[corner] <= slot_rd.vertex;
            if (corner == 2'd2) begin
              state <= B_DONE;
            end else begin
              corner <= corner_nx;
              pos    <= cur.hash[corner_nx];
              state  <= B_PROBE;
            end
          end else begin
            // Linear probe, wraps at the table size
            pos   <= pos + 1'b1;
            state <= B_PROBE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            if (kept) kept_any <= 1'b1;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Raise valid as an item is delivered, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded as the item is delivered
  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      res_data.index0       <= idx[0];
      res_data.index1       <= idx[1];
      res_data.index2       <= idx[2];
      res_data.new_mask     <= mask;
      res_data.kept         <= kept;
      res_data.vertex_total <= vcount;
      res_data.table_full   <= full;
      res_data.mesh_empty   <= cur.last && !(kept_any || kept);
      res_data.last_out     <= cur.last;
    end
  end

endmodule

// ----- hdl/vertex_weld_dedup_unit.sv -----
// Vertex welding unit: turns a stream of raw triangles into indexed triangles.
// In the front a triangle passes the MIX and PUSH states (hash mixing), and
// the front takes no new triangle until it is pushed. In the back each corner
// steps through PROBE and SLOT, and through KEY as well when the slot is live;
// a new vertex ends at SLOT, and every extra linear probe repeats PROBE, SLOT
// and KEY. After reset, and on every 255th first_of_mesh, the back
// sweeps all 8192 hash slots (one per cycle) before it handles another
// triangle; meanwhile up to three triangles wait in the front and queue.
// Depends on vwd_pkg, vwd_front, vwd_queue and vwd_back.
module vertex_weld_dedup_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              tri_valid,
  output logic              tri_stall,
  input  vwd_pkg::tri_in_t  tri_data,
  output logic              res_valid,
  input  logic              res_stall,
  output vwd_pkg::tri_out_t res_data
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  vwd_pkg::work_t push_data;
  vwd_pkg::work_t head;

  vwd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .tri_data  (tri_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  vwd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  vwd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
